// ===== hdl/ddsftw_pkg.sv =====
// ----------------------------------------------------------------------------
// DDS tuning word package
// Widths, reset values, register indexes and the divider stage record shared
// by the tuning word calculator and its channel interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddsftw_pkg;

    // Field and register widths.
    localparam int TARGET_W  = 32;
    localparam int TW_W      = 48;
    localparam int REF_W     = 29;
    localparam int PLL_W     = 5;
    localparam int SYSCLK_W  = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Register reset values.
    localparam logic [REF_W-1:0] REF_RESET = REF_W'(20000000);
    localparam logic [PLL_W-1:0] PLL_RESET = PLL_W'(1);

    // Register index, taken from bit 2 of the byte address.
    localparam int REG_IDX_BIT = 2;

    typedef enum logic {
        REG_REF_CLOCK = 1'b0,
        REG_PLL_MULT  = 1'b1
    } reg_idx_t;

    // Long division: 64-bit dividend by 32-bit divisor.
    localparam int DIVIDEND_W      = 64;
    localparam int DIVISOR_W       = 32;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = DIVIDEND_W / STEPS_PER_STAGE;

    // One record of the divider pipeline. The dividend bits not yet consumed
    // sit at the top of dq while quotient bits fill in from the bottom.
    typedef struct packed {
        logic [DIVISOR_W-1:0]  rem;
        logic [DIVIDEND_W-1:0] dq;
        logic [DIVISOR_W-1:0]  div;
        logic                  sel;
        logic                  clamped;
        logic                  status;
    } div_rec_t;

endpackage : ddsftw_pkg

`default_nettype wire

// ===== hdl/ddsftw_if.sv =====
// ----------------------------------------------------------------------------
// DDS tuning word channels
// Valid/ready channels for the frequency request item and the tuning word
// result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ddsftw_in_if
    import ddsftw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target_hz;
    logic                word_select;

    modport source (output valid, output target_hz, output word_select, input ready);
    modport sink   (input valid, input target_hz, input word_select, output ready);
endinterface : ddsftw_in_if

interface ddsftw_out_if
    import ddsftw_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [TW_W-1:0] tuning_word;
    logic            word_target;
    logic            was_clamped;
    logic            status;

    modport source (output valid, output tuning_word, output word_target,
                    output was_clamped, output status, input ready);
    modport sink   (input valid, input tuning_word, input word_target,
                    input was_clamped, input status, output ready);
endinterface : ddsftw_out_if

`default_nettype wire

// ===== hdl/dds_frequency_tuning_word.sv =====
// Throughput: one item per cycle; the pipeline only holds when a finished
// result waits at the output register and the sink is not ready.
// The pipeline holds the 16-stage long divider, four quotient bits per stage,
// behind the clamp and normalize stages. Reset (rst_n low, asynchronous)
// empties the pipeline and sets the reference clock to 20 MHz and the
// multiplier to 1.
// ----------------------------------------------------------------------------
// DDS frequency tuning word calculator
// Turns a wanted output frequency into a synthesizer tuning word,
// floor(f * 2^ACC_BITS / sysclk), with clamping at half of sysclk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_frequency_tuning_word
    import ddsftw_pkg::*;
#(
    parameter int ACC_BITS = 48
) (
    input  wire                   clk,
    input  wire                   rst_n,

    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_AW-1:0]     paddr,
    input  wire  [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,

    ddsftw_in_if.sink             in_ch,
    ddsftw_out_if.source          out_ch
);

    // Shifts that the normalization may make beyond the first 32 places.
    localparam logic [5:0] REST0  = 6'(ACC_BITS - 32);
    localparam int         STAGES = DIV_STAGES + 2;
    localparam int         LAST   = STAGES - 1;

    // Mask that keeps the low ACC_BITS bits of the quotient within the field.
    localparam logic [TW_W-1:0] ACC_MASK =
        (ACC_BITS >= TW_W) ? {TW_W{1'b1}} : TW_W'((64'(1) << ACC_BITS) - 64'(1));

    // ------------------------------------------------------------------
    // Configuration registers. The register index comes from one address
    // bit, so every write lands in one of the two registers.
    // ------------------------------------------------------------------
    logic [REF_W-1:0] ref_clock_reg;
    logic [PLL_W-1:0] pll_mult_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[REG_IDX_BIT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_clock_reg <= REF_RESET;
            pll_mult_reg  <= PLL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_REF_CLOCK: ref_clock_reg <= pwdata[REF_W-1:0];
                REG_PLL_MULT:  pll_mult_reg  <= pwdata[PLL_W-1:0];
                default:       ref_clock_reg <= ref_clock_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_REF_CLOCK: prdata = APB_DW'(ref_clock_reg);
            REG_PLL_MULT:  prdata = APB_DW'(pll_mult_reg);
            default:       prdata = '0;
        endcase
    end

    // The system clock is the product kept modulo 2^32, used directly. The user
    // must change configuration only while the pipeline is empty (not enforced).
    logic [REF_W+PLL_W-1:0] sysclk_full;
    logic [SYSCLK_W-1:0]    sysclk;
    logic [SYSCLK_W-2:0]    sysclk_half;

    assign sysclk_full = (REF_W+PLL_W)'(ref_clock_reg) * (REF_W+PLL_W)'(pll_mult_reg);
    assign sysclk      = sysclk_full[SYSCLK_W-1:0];
    assign sysclk_half = sysclk[SYSCLK_W-1:1];

    // ------------------------------------------------------------------
    // Pipeline control. All stages move together; a stage holds only when
    // the output register is full and the sink is not taking it.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] vld_reg;
    logic              adv;

    assign adv         = !vld_reg[LAST] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_ch.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage A: the accepted item. Clamp to half of sysclk and find how far
    // the normalization shifts. The first shift is always made; after it
    // the loop stops on the first set bit, so the count is one plus the
    // leading zeros of bits 30..0, limited to REST0.
    // ------------------------------------------------------------------
    logic [TARGET_W-1:0] a_tgt_reg;
    logic                a_sel_reg;
    logic                a_over;
    logic [TARGET_W-2:0] a_tgt_clamped;
    logic [5:0]          a_lz;
    logic [5:0]          a_shift_cand;
    logic [5:0]          a_shift;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_tgt_reg <= in_ch.target_hz;
            a_sel_reg <= in_ch.word_select;
        end
    end

    // A value that is not above half fits in 31 bits, as half is below 2^31.
    assign a_over        = a_tgt_reg > {1'b0, sysclk_half};
    assign a_tgt_clamped = a_over ? sysclk_half : a_tgt_reg[TARGET_W-2:0];

    always_comb
    begin
        a_lz = 6'd31;
        for (int i = 0; i < TARGET_W - 1; i++)
        begin
            if (a_tgt_clamped[i])
            begin
                a_lz = 6'(TARGET_W - 2 - i);
            end
        end
    end

    assign a_shift_cand = a_lz + 6'd1;
    assign a_shift      = (a_shift_cand > REST0) ? REST0 : a_shift_cand;

    // ------------------------------------------------------------------
    // Stage B: build the normalized dividend and the shifted divisor.
    // ------------------------------------------------------------------
    logic [TARGET_W-2:0]   b_tgt_reg;
    logic [5:0]            b_shift_reg;
    logic                  b_sel_reg;
    logic                  b_clamped_reg;
    logic [DIVIDEND_W-1:0] b_dividend;
    logic [5:0]            b_rest;
    logic [DIVISOR_W-1:0]  b_divisor;
    div_rec_t              b_rec;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_tgt_reg     <= a_tgt_clamped;
            b_shift_reg   <= a_shift;
            b_sel_reg     <= a_sel_reg;
            b_clamped_reg <= a_over;
        end
    end

    assign b_dividend = {1'b0, b_tgt_reg, 32'b0} << b_shift_reg;
    assign b_rest     = REST0 - b_shift_reg;
    assign b_divisor  = b_rest[5] ? '0 : (sysclk >> b_rest[4:0]);

    always_comb
    begin
        b_rec         = '0;
        b_rec.dq      = b_dividend;
        b_rec.div     = b_divisor;
        b_rec.sel     = b_sel_reg;
        b_rec.clamped = b_clamped_reg;
        b_rec.status  = (b_divisor == '0);
    end

    // ------------------------------------------------------------------
    // Divider stages: restoring division, several quotient bits per stage.
    // ------------------------------------------------------------------
    function automatic div_rec_t div_step(input div_rec_t rec);
        div_rec_t          r;
        logic [DIVISOR_W:0] part;
        r = rec;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            part = {r.rem, r.dq[DIVIDEND_W-1]};
            r.dq = {r.dq[DIVIDEND_W-2:0], 1'b0};
            if (part >= {1'b0, r.div})
            begin
                part    = part - {1'b0, r.div};
                r.dq[0] = 1'b1;
            end
            r.rem = part[DIVISOR_W-1:0];
        end
        return r;
    endfunction

    div_rec_t div_reg  [DIV_STAGES];
    div_rec_t div_next [DIV_STAGES];

    always_comb
    begin
        div_next[0] = div_step(b_rec);
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            div_next[s] = div_step(div_reg[s-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                div_reg[s] <= div_next[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: the last divider stage is the output register.
    // ------------------------------------------------------------------
    div_rec_t last_rec;

    assign last_rec           = div_reg[DIV_STAGES-1];
    assign out_ch.valid       = vld_reg[LAST];
    assign out_ch.tuning_word = last_rec.status ? '0 : (last_rec.dq[TW_W-1:0] & ACC_MASK);
    assign out_ch.word_target = last_rec.sel;
    assign out_ch.was_clamped = last_rec.clamped;
    assign out_ch.status      = last_rec.status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST] && !last_rec.status |-> last_rec.rem < last_rec.div)
        else $error("divider remainder not below divisor");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (b_shift_reg >= 6'd1) && (b_shift_reg <= REST0))
        else $error("normalization shift out of range");

endmodule : dds_frequency_tuning_word

`default_nettype wire
